### rtl/mppod_pkg.sv
// Shared types, widths and codes for the perturb-and-observe duty tracker.
package mppod_pkg;

    localparam int DUTY_BITS      = 10;
    localparam int SAMPLE_BITS    = 16;
    localparam int POWER_BITS     = 2 * SAMPLE_BITS;
    localparam int THRESH_BITS    = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam int REQ_BITS       = 3;
    localparam int S_TDATA_BITS   = 2 * SAMPLE_BITS;
    localparam int S_TUSER_BITS   = REQ_BITS + 1;
    localparam int M_FIELD_BITS   = DUTY_BITS + 2;
    localparam int M_TDATA_BITS   = ((M_FIELD_BITS + 7) / 8) * 8;
    localparam int M_PAD_BITS     = M_TDATA_BITS - M_FIELD_BITS;

    // Register reset values
    localparam logic [DUTY_BITS-1:0]   DUTY_MIN_RST    = '0;
    localparam logic [DUTY_BITS-1:0]   DUTY_MAX_RST    = '1;
    localparam logic [DUTY_BITS-1:0]   COARSE_STEP_RST = DUTY_BITS'(8);
    localparam logic [DUTY_BITS-1:0]   FINE_STEP_RST   = DUTY_BITS'(1);
    localparam logic [THRESH_BITS-1:0] THRESHOLD_RST   = '0;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_MPPT   = 3'd0,
        REQ_SWEEP  = 3'd1,
        REQ_UP     = 3'd2,
        REQ_DOWN   = 3'd3,
        REQ_ON     = 3'd4,
        REQ_OFF    = 3'd5,
        REQ_STOP   = 3'd6
    } req_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DUTY_MIN    = 3'd0,
        CFG_DUTY_MAX    = 3'd1,
        CFG_COARSE_STEP = 3'd2,
        CFG_FINE_STEP   = 3'd3,
        CFG_THRESHOLD   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0]   duty_min;
        logic [DUTY_BITS-1:0]   duty_max;
        logic [DUTY_BITS-1:0]   coarse_step;
        logic [DUTY_BITS-1:0]   fine_step;
        logic [THRESH_BITS-1:0] restart_current;
    } cfg_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0]  duty;
        logic [POWER_BITS-1:0] reference_power;
        logic                  direction_up;
        logic                  sweep_reversing;
        logic                  driver_enabled;
    } trk_state_t;

endpackage

### rtl/mppt_perturb_observe_duty.sv
// Top level: perturb-and-observe MPPT duty tracker with stream ports and a config write channel.
// Pipeline: an input transfer passes the input register, the product register and the result register
// before its result is offered on m_; the 16x16
// power multiply sets the middle stage.
// Throughput: one item per cycle while m_tready is high; a stage moves when the next is empty or
// moving, so a stalled result holds only the output register and the two stages behind it fill.
// Reset (aresetn low, synchronous): all stages empty, config registers and tracker state
// return to their defaults (duty 0, reference power 0, direction up, driver off).
module mppt_perturb_observe_duty
    import mppod_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    // Config write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    // Request stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [S_TDATA_BITS-1:0]   s_tdata,   // voltage_sample[15:0], current_sample[31:16]
    input  logic [S_TUSER_BITS-1:0]   s_tuser,   // req_type[2:0], use_fine[3]

    // Result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [M_TDATA_BITS-1:0]   m_tdata    // duty[9:0], output_enabled[10],
                                                 // stepping_up[11], zero pad[15:12]
);

    // Config registers
    cfg_t cfg_reg;

    // Pipeline stages
    logic                   in_valid_reg;
    req_t                   in_req_reg;
    logic                   in_fine_reg;
    logic [SAMPLE_BITS-1:0] in_volt_reg;
    logic [SAMPLE_BITS-1:0] in_curr_reg;

    logic                   mul_valid_reg;
    req_t                   mul_req_reg;
    logic                   mul_fine_reg;
    logic [SAMPLE_BITS-1:0] mul_curr_reg;
    logic [POWER_BITS-1:0]  mul_power_reg;

    logic                   out_valid_reg;
    logic [DUTY_BITS-1:0]   out_duty_reg;
    logic                   out_en_reg;
    logic                   out_up_reg;

    // Tracker state
    trk_state_t             st_reg;
    trk_state_t             st_next;

    logic ready_out;
    logic ready_mul;
    logic in_xfer;
    logic state_upd;

    // Each stage advances when the next one is free or draining this cycle
    assign ready_out = ~out_valid_reg | m_tready;
    assign ready_mul = ~mul_valid_reg | ready_out;
    assign s_tready  = ~in_valid_reg | ready_mul;
    assign in_xfer   = s_tvalid & s_tready;
    // State commits exactly when an item lands in the result register
    assign state_upd = mul_valid_reg & ready_out;

    assign cfg_ready = 1'b1;

    // Config writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.duty_min        <= DUTY_MIN_RST;
            cfg_reg.duty_max        <= DUTY_MAX_RST;
            cfg_reg.coarse_step     <= COARSE_STEP_RST;
            cfg_reg.fine_step       <= FINE_STEP_RST;
            cfg_reg.restart_current <= THRESHOLD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DUTY_MIN:    cfg_reg.duty_min        <= cfg_data[DUTY_BITS-1:0];
                CFG_DUTY_MAX:    cfg_reg.duty_max        <= cfg_data[DUTY_BITS-1:0];
                CFG_COARSE_STEP: cfg_reg.coarse_step     <= cfg_data[DUTY_BITS-1:0];
                CFG_FINE_STEP:   cfg_reg.fine_step       <= cfg_data[DUTY_BITS-1:0];
                CFG_THRESHOLD:   cfg_reg.restart_current <= cfg_data[THRESH_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stage 1: capture the request transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_req_reg  <= req_t'(s_tuser[REQ_BITS-1:0]);
            in_fine_reg <= s_tuser[REQ_BITS];
            in_volt_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_curr_reg <= s_tdata[S_TDATA_BITS-1:SAMPLE_BITS];
        end
    end

    // Stage 2: form power as voltage times current
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (ready_mul) begin
            mul_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_mul && in_valid_reg) begin
            mul_req_reg   <= in_req_reg;
            mul_fine_reg  <= in_fine_reg;
            mul_curr_reg  <= in_curr_reg;
            mul_power_reg <= POWER_BITS'(in_volt_reg * in_curr_reg);
        end
    end

    // Stage 3: apply the request to the tracker state
    mppod_step u_step (
        .cfg            (cfg_reg),
        .st             (st_reg),
        .req            (mul_req_reg),
        .use_fine       (mul_fine_reg),
        .current_sample (mul_curr_reg),
        .power          (mul_power_reg),
        .st_next        (st_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.duty            <= DUTY_MIN_RST;
            st_reg.reference_power <= '0;
            st_reg.direction_up    <= 1'b1;
            st_reg.sweep_reversing <= 1'b0;
            st_reg.driver_enabled  <= 1'b0;
        end else if (state_upd) begin
            st_reg <= st_next;
        end
    end

    // Result register; hold while the sink stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ready_out) begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_upd) begin
            out_duty_reg <= st_next.duty;
            out_en_reg   <= st_next.driver_enabled;
            out_up_reg   <= st_next.direction_up;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_BITS{1'b0}}, out_up_reg, out_en_reg, out_duty_reg};

    // A result appears only from an item that sat in the product stage
    a_out_from_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(mul_valid_reg))
        else $error("result valid without a product-stage item");

    // The pending result always reflects the committed tracker state
    a_out_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_upd) |-> (out_duty_reg == st_reg.duty &&
                              out_en_reg == st_reg.driver_enabled &&
                              out_up_reg == st_reg.direction_up))
        else $error("result register out of step with tracker state");

    // An MPPT tick always enables the driver and takes the new power as reference
    a_mppt_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_upd && mul_req_reg == REQ_MPPT) |=>
            (st_reg.driver_enabled && st_reg.reference_power == $past(mul_power_reg)))
        else $error("MPPT tick did not update driver or reference power");

    // Stop parks the duty at the minimum with the driver off
    a_stop_parks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_upd && mul_req_reg == REQ_STOP) |=>
            (st_reg.duty == cfg_reg.duty_min && !st_reg.driver_enabled &&
             st_reg.direction_up))
        else $error("stop did not park the tracker");

    // State never moves without an item landing in the result register
    a_state_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_upd |=> $stable(st_reg))
        else $error("tracker state changed without a committed item");

endmodule

### rtl/mppod_step.sv
// Next-state logic of the tracker: one request applied to the current state.
module mppod_step
    import mppod_pkg::*;
(
    input  cfg_t                   cfg,
    input  trk_state_t             st,
    input  req_t                   req,
    input  logic                   use_fine,
    input  logic [SAMPLE_BITS-1:0] current_sample,
    input  logic [POWER_BITS-1:0]  power,
    output trk_state_t             st_next
);

    logic [DUTY_BITS-1:0] step;
    logic [DUTY_BITS:0]   up_sum;
    logic [DUTY_BITS:0]   down_floor;
    logic [DUTY_BITS-1:0] duty_up;
    logic [DUTY_BITS-1:0] duty_down;
    logic                 dir_mppt;

    // Fine step only on a manual move that asks for it
    always_comb begin
        step = ((req == REQ_UP || req == REQ_DOWN) && use_fine) ? cfg.fine_step
                                                               : cfg.coarse_step;
    end

    // Saturating moves, formed one bit wider so nothing wraps
    always_comb begin
        up_sum     = {1'b0, st.duty} + {1'b0, step};
        down_floor = {1'b0, cfg.duty_min} + {1'b0, step};
        duty_up    = (up_sum > {1'b0, cfg.duty_max}) ? cfg.duty_max
                                                     : up_sum[DUTY_BITS-1:0];
        duty_down  = ({1'b0, st.duty} < down_floor) ? cfg.duty_min : st.duty - step;
    end

    // Reverse on a power drop, keep otherwise
    assign dir_mppt = (power < st.reference_power) ? ~st.direction_up : st.direction_up;

    always_comb begin
        st_next = st;
        unique case (req)
            REQ_MPPT: begin
                st_next.driver_enabled  = 1'b1;
                st_next.reference_power = power;
                if (current_sample < cfg.restart_current) begin
                    st_next.direction_up = 1'b1;
                    st_next.duty         = cfg.duty_min;
                end else begin
                    st_next.direction_up = dir_mppt;
                    st_next.duty         = dir_mppt ? duty_up : duty_down;
                end
            end
            REQ_SWEEP: begin
                st_next.driver_enabled = 1'b1;
                if (!st.sweep_reversing) begin
                    if (st.duty >= cfg.duty_max) begin
                        st_next.sweep_reversing = 1'b1;
                    end else begin
                        st_next.duty = duty_up;
                    end
                end else begin
                    if (st.duty <= cfg.duty_min) begin
                        st_next.sweep_reversing = 1'b0;
                    end else begin
                        st_next.duty = duty_down;
                    end
                end
            end
            REQ_UP: begin
                st_next.duty = duty_up;
            end
            REQ_DOWN: begin
                st_next.duty = duty_down;
            end
            REQ_ON: begin
                st_next.driver_enabled = 1'b1;
            end
            REQ_OFF: begin
                st_next.driver_enabled = 1'b0;
            end
            REQ_STOP: begin
                st_next.direction_up   = 1'b1;
                st_next.driver_enabled = 1'b0;
                st_next.duty           = cfg.duty_min;
            end
            default: begin
                st_next = st;
            end
        endcase
    end

endmodule
